// File: rtl/core/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// Shared widths, constants and pipeline word types for the vector normalizer.
// ----------------------------------------------------------------------------
package vn_pkg;

	localparam int CompW    = 24;
	localparam int OutFracW = 16;
	localparam int UnitW    = OutFracW + 2;
	localparam int QuotW    = OutFracW + 1;
	localparam int SqW      = 2 * CompW - 1;
	localparam int SumW     = 2 * CompW;
	localparam int RootW    = CompW;
	localparam int RemW     = RootW + 2;
	localparam int DRemW    = CompW + 1;
	localparam int Lanes    = 3;
	localparam int SqrtSteps = RootW;
	localparam int DivSteps  = QuotW;

	typedef logic [CompW-1:0] comp_t;

	typedef struct packed {
		logic [SumW-1:0]  n;
		logic [RemW-1:0]  r;
		logic [RootW-1:0] q;
		comp_t [Lanes-1:0] a;
		logic [Lanes-1:0]  neg;
	} vn_sqrt_t;

	typedef struct packed {
		logic [RootW-1:0]             mag;
		logic [Lanes-1:0]             neg;
		logic [Lanes-1:0][DRemW-1:0]  rem;
		logic [Lanes-1:0][QuotW-1:0]  q;
	} vn_div_t;

endpackage

// File: rtl/core/vn_vec_if.sv
// ----------------------------------------------------------------------------
// vn_vec_if
// Input word channel: one signed Q12.12 vector.
// ----------------------------------------------------------------------------
interface vn_vec_if;
	import vn_pkg::*;
	logic              valid;
	logic              ready;
	logic signed [CompW-1:0] in_x;
	logic signed [CompW-1:0] in_y;
	logic signed [CompW-1:0] in_z;
	modport source (output valid, in_x, in_y, in_z, input ready);
	modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

// File: rtl/core/vn_unit_if.sv
// ----------------------------------------------------------------------------
// vn_unit_if
// Result word channel: unit vector, magnitude and zero flag.
// ----------------------------------------------------------------------------
interface vn_unit_if;
	import vn_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [UnitW-1:0] unit_x;
	logic signed [UnitW-1:0] unit_y;
	logic signed [UnitW-1:0] unit_z;
	logic [CompW-1:0]        magnitude;
	logic                    zero_vector;
	modport source (output valid, unit_x, unit_y, unit_z, magnitude, zero_vector,
		input ready);
	modport sink (input valid, unit_x, unit_y, unit_z, magnitude, zero_vector,
		output ready);
endinterface

// File: rtl/core/vn_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vn_sqrt_cell
// One root digit: shift in two radicand bits, try the subtract, pass on.
// ----------------------------------------------------------------------------
module vn_sqrt_cell
	import vn_pkg::*;
(
	input  logic     clk,
	input  logic     en,
	input  vn_sqrt_t d,
	output vn_sqrt_t q_q
);
	logic [RemW+1:0] work;
	logic [RemW+1:0] trial;
	logic            take;
	vn_sqrt_t        nxt;

	always_comb begin
		work  = {d.r, d.n[SumW-1 -: 2]};
		trial = {2'b00, d.q, 2'b01};
		take  = work >= trial;
		nxt   = d;
		nxt.n = {d.n[SumW-3:0], 2'b00};
		if (take) begin
			nxt.r = RemW'(work - trial);
			nxt.q = {d.q[RootW-2:0], 1'b1};
		end else begin
			nxt.r = RemW'(work);
			nxt.q = {d.q[RootW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_q <= nxt;
		end
	end
endmodule

// File: rtl/core/vn_div_cell.sv
// ----------------------------------------------------------------------------
// vn_div_cell
// One quotient bit for all three lanes: compare against magnitude, subtract.
// ----------------------------------------------------------------------------
module vn_div_cell
	import vn_pkg::*;
(
	input  logic    clk,
	input  logic    en,
	input  vn_div_t d,
	output vn_div_t q_q
);
	vn_div_t              nxt;
	logic [DRemW-1:0]     diff;

	always_comb begin
		nxt  = d;
		diff = '0;
		for (int i = 0; i < Lanes; i++) begin
			if (d.rem[i] >= {1'b0, d.mag}) begin
				diff       = d.rem[i] - {1'b0, d.mag};
				nxt.q[i]   = {d.q[i][QuotW-2:0], 1'b1};
			end else begin
				diff       = d.rem[i];
				nxt.q[i]   = {d.q[i][QuotW-2:0], 1'b0};
			end
			nxt.rem[i] = {diff[DRemW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_q <= nxt;
		end
	end
endmodule

// File: rtl/core/vector3_normalize_core.sv
// ----------------------------------------------------------------------------
// vector3_normalize_core
// Normalizes one signed Q12.12 3D vector per word into a Q1.16 unit vector.
// ----------------------------------------------------------------------------
// vec (sink): in_x, in_y, in_z, signed Q12.12.
// res (source): unit_x/y/z signed Q1.16 truncated toward zero, magnitude
//   unsigned Q12.12 (floor of root), zero_vector set for an all-zero input.
// Pipeline from acceptance to the result word: one squaring
//   stage, one sum stage, a chain of 24 root cells (one digit each), a
//   chain of 17 divide cells (one quotient bit each for all lanes), and
//   the output register.
// Throughput: one word per cycle while res does not stall; the root and divide chains set it.
// The whole pipeline advances together; when res stalls with a word in
//   the output register, everything holds and vec.ready drops.
// Reset clears the valid bits only; no word is in flight afterward.
// ----------------------------------------------------------------------------
module vector3_normalize_core
	import vn_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	vn_vec_if.sink   vec,
	vn_unit_if.source res
);
	localparam int Stages = 2 + SqrtSteps + DivSteps;

	logic                    adv;
	logic [Stages-1:0]       vld_q;
	logic                    out_vld_q;

	comp_t [Lanes-1:0]       abs_c;
	logic [Lanes-1:0]        neg_c;
	logic [SqW-1:0]          sq_s1 [Lanes];
	comp_t [Lanes-1:0]       a_s1;
	logic [Lanes-1:0]        neg_s1;
	vn_sqrt_t                sq_chain [SqrtSteps+1];
	vn_div_t                 dv_chain [DivSteps+1];
	logic [UnitW-1:0]        unit_c [Lanes];

	logic signed [UnitW-1:0] ux_q, uy_q, uz_q;
	logic [CompW-1:0]        mag_q;
	logic                    zero_q;

	assign adv       = !out_vld_q || res.ready;
	assign vec.ready = adv;

	always_comb begin
		abs_c[0] = vec.in_x[CompW-1] ? comp_t'(-vec.in_x) : comp_t'(vec.in_x);
		abs_c[1] = vec.in_y[CompW-1] ? comp_t'(-vec.in_y) : comp_t'(vec.in_y);
		abs_c[2] = vec.in_z[CompW-1] ? comp_t'(-vec.in_z) : comp_t'(vec.in_z);
		neg_c    = {vec.in_z[CompW-1], vec.in_y[CompW-1], vec.in_x[CompW-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[Stages-2:0], vec.valid};
			out_vld_q <= vld_q[Stages-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < Lanes; i++) begin
				sq_s1[i] <= SqW'(abs_c[i] * abs_c[i]);
			end
			a_s1   <= abs_c;
			neg_s1 <= neg_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_chain[0].n   <= SumW'(sq_s1[0]) + SumW'(sq_s1[1]) + SumW'(sq_s1[2]);
			sq_chain[0].r   <= '0;
			sq_chain[0].q   <= '0;
			sq_chain[0].a   <= a_s1;
			sq_chain[0].neg <= neg_s1;
		end
	end

	for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
		vn_sqrt_cell u_cell (
			.clk (clk),
			.en  (adv),
			.d   (sq_chain[g]),
			.q_q (sq_chain[g+1])
		);
	end

	always_comb begin
		dv_chain[0].mag = sq_chain[SqrtSteps].q;
		dv_chain[0].neg = sq_chain[SqrtSteps].neg;
		for (int i = 0; i < Lanes; i++) begin
			dv_chain[0].rem[i] = {1'b0, sq_chain[SqrtSteps].a[i]};
			dv_chain[0].q[i]   = '0;
		end
	end

	for (genvar g = 0; g < DivSteps; g++) begin : g_div
		vn_div_cell u_cell (
			.clk (clk),
			.en  (adv),
			.d   (dv_chain[g]),
			.q_q (dv_chain[g+1])
		);
	end

	always_comb begin
		for (int i = 0; i < Lanes; i++) begin
			if (dv_chain[DivSteps].mag == '0) begin
				unit_c[i] = '0;
			end else if (dv_chain[DivSteps].neg[i]) begin
				unit_c[i] = UnitW'(-{1'b0, dv_chain[DivSteps].q[i]});
			end else begin
				unit_c[i] = {1'b0, dv_chain[DivSteps].q[i]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ux_q   <= unit_c[0];
			uy_q   <= unit_c[1];
			uz_q   <= unit_c[2];
			mag_q  <= dv_chain[DivSteps].mag;
			zero_q <= dv_chain[DivSteps].mag == '0;
		end
	end

	assign res.valid       = out_vld_q;
	assign res.unit_x      = ux_q;
	assign res.unit_y      = uy_q;
	assign res.unit_z      = uz_q;
	assign res.magnitude   = mag_q;
	assign res.zero_vector = zero_q;

	a_zero_units: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.zero_vector |-> res.unit_x == '0 && res.unit_y == '0
			&& res.unit_z == '0)
		else $error("zero vector with nonzero unit component");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.zero_vector == (res.magnitude == '0))
		else $error("zero flag disagrees with magnitude");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!vec.ready |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> vec.ready)
		else $error("input blocked with empty output");

endmodule

// File: tb/tb_vector3_normalize_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector3_normalize_core
// Streams signed Q12.12 vectors through the normalizer and checks every
// result word (unit vector, magnitude, zero flag) against table values or an
// in-bench predictor, under several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module tb_vector3_normalize_core;
	import vn_pkg::*;

	localparam int StallLimit = 4000;
	localparam int DrainCycles = 60;

	typedef struct packed {
		logic signed [UnitW-1:0] ux;
		logic signed [UnitW-1:0] uy;
		logic signed [UnitW-1:0] uz;
		logic [CompW-1:0]        mag;
		logic                    zero;
	} unit_word_t;

	typedef struct {
		logic signed [CompW-1:0] x;
		logic signed [CompW-1:0] y;
		logic signed [CompW-1:0] z;
		bit                      known;
		unit_word_t              res;
	} vec_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	vn_vec_if  vec ();
	vn_unit_if res ();

	vector3_normalize_core dut (.clk(clk), .arst_n(arst_n), .vec(vec), .res(res));

	always #4 clk = ~clk;

	unit_word_t pending_units[$];
	int         mismatches = 0;
	int         idle_cycles = 0;
	int         send_idle_pct = 0;
	int         stall_pct = 0;
	bit         sending_done = 1'b0;

	function automatic logic [63:0] floor_root(logic [63:0] n);
		logic [63:0] root;
		logic [63:0] bitv;
		root = '0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic [UnitW-1:0] unit_part(logic signed [CompW-1:0] c,
		logic [63:0] mag);
		logic [63:0] size;
		logic [63:0] q;
		size = (c < 0) ? 64'(-64'(c)) : 64'(c);
		if (mag == 0)
			return '0;
		q = (size << OutFracW) / mag;
		if (q > (64'd1 << OutFracW))
			q = 64'd1 << OutFracW;
		if (c < 0)
			q = -q;
		return q[UnitW-1:0];
	endfunction

	function automatic unit_word_t normalize(logic signed [CompW-1:0] x,
		logic signed [CompW-1:0] y, logic signed [CompW-1:0] z);
		unit_word_t w;
		logic signed [63:0] sx, sy, sz;
		logic [63:0] mag;
		sx = 64'(x);
		sy = 64'(y);
		sz = 64'(z);
		mag = floor_root(64'(sx * sx) + 64'(sy * sy) + 64'(sz * sz));
		w.ux = unit_part(x, mag);
		w.uy = unit_part(y, mag);
		w.uz = unit_part(z, mag);
		w.mag = mag[CompW-1:0];
		w.zero = (mag == 0);
		return w;
	endfunction

	localparam logic signed [CompW-1:0] MaxC = {1'b0, {(CompW-1){1'b1}}};
	localparam logic signed [CompW-1:0] MinC = {1'b1, {(CompW-1){1'b0}}};

	vec_row_t directed[21] = '{
		'{24'sd0, 24'sd0, 24'sd0, 1'b1, '{18'sd0, 18'sd0, 18'sd0, 24'd0, 1'b1}},
		'{24'sd4096, 24'sd0, 24'sd0, 1'b1, '{18'sd65536, 18'sd0, 18'sd0, 24'd4096, 1'b0}},
		'{24'sd0, -24'sd4096, 24'sd0, 1'b1, '{18'sd0, -18'sd65536, 18'sd0, 24'd4096, 1'b0}},
		'{24'sd0, 24'sd0, 24'sd1, 1'b1, '{18'sd0, 18'sd0, 18'sd65536, 24'd1, 1'b0}},
		'{MaxC, 24'sd0, 24'sd0, 1'b1, '{18'sd65536, 18'sd0, 18'sd0, 24'd8388607, 1'b0}},
		'{MinC, 24'sd0, 24'sd0, 1'b1, '{-18'sd65536, 18'sd0, 18'sd0, 24'd8388608, 1'b0}},
		'{24'sd0, MinC, 24'sd0, 1'b1, '{18'sd0, -18'sd65536, 18'sd0, 24'd8388608, 1'b0}},
		'{24'sd0, 24'sd0, MinC, 1'b1, '{18'sd0, 18'sd0, -18'sd65536, 24'd8388608, 1'b0}},
		'{-24'sd1, 24'sd0, 24'sd0, 1'b1, '{-18'sd65536, 18'sd0, 18'sd0, 24'd1, 1'b0}},
		'{MinC, MinC, MinC, 1'b0, '0},
		'{MaxC, MaxC, MaxC, 1'b0, '0},
		'{MaxC, MinC, MaxC, 1'b0, '0},
		'{MinC, MaxC, MinC, 1'b0, '0},
		'{24'sd1, 24'sd1, 24'sd1, 1'b0, '0},
		'{-24'sd1, -24'sd1, -24'sd1, 1'b0, '0},
		'{24'sd3, 24'sd4, 24'sd0, 1'b0, '0},
		'{24'sd4096, 24'sd4096, 24'sd4096, 1'b0, '0},
		'{-24'sd12288, 24'sd16384, 24'sd0, 1'b0, '0},
		'{24'sd1, MaxC, 24'sd0, 1'b0, '0},
		'{24'h555555, 24'hAAAAAA, 24'h0F0F0F, 1'b0, '0},
		'{24'hAAAAAA, 24'h555555, 24'hF0F0F0, 1'b0, '0}
	};

	task automatic send_word(logic signed [CompW-1:0] x, logic signed [CompW-1:0] y,
		logic signed [CompW-1:0] z, unit_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			vec.valid <= 1'b0;
			@(posedge clk);
		end
		vec.valid <= 1'b1;
		vec.in_x <= x;
		vec.in_y <= y;
		vec.in_z <= z;
		pending_units.push_back(w);
		do
			@(posedge clk);
		while (!vec.ready);
	endtask

	function automatic logic signed [CompW-1:0] rand_comp();
		case ($urandom_range(5))
			0: return CompW'($urandom_range(8)) - 24'sd4;
			1: return $signed(24'($urandom_range(65535))) - 24'sd32768;
			2: return $urandom_range(1) ? MaxC - CompW'($urandom_range(3)) :
				MinC + CompW'($urandom_range(3));
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic wait_drained();
		vec.valid <= 1'b0;
		while (pending_units.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic signed [CompW-1:0] x, y, z;
		vec.valid = 1'b0;
		vec.in_x = '0;
		vec.in_y = '0;
		vec.in_z = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_word(directed[i].x, directed[i].y, directed[i].z,
				directed[i].known ? directed[i].res :
				normalize(directed[i].x, directed[i].y, directed[i].z));
		wait_drained();
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 20 : 78) : 0;
			stall_pct = (phase == 2) ? 78 : ((phase == 3) ? 20 : 0);
			for (int k = 0; k < 335; k++) begin
				x = rand_comp();
				y = rand_comp();
				z = rand_comp();
				if ($urandom_range(29) == 0) begin
					x = '0;
					y = '0;
					z = '0;
				end
				send_word(x, y, z, normalize(x, y, z));
			end
			wait_drained();
		end
		sending_done = 1'b1;
	end

	always @(posedge clk) begin
		res.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		unit_word_t w;
		if (res.valid && res.ready && arst_n) begin
			if (pending_units.size() == 0) begin
				$error("unexpected result word");
				mismatches++;
			end else begin
				w = pending_units.pop_front();
				if (res.unit_x !== w.ux) begin
					$error("unit_x expected %0d actual %0d", w.ux, res.unit_x);
					mismatches++;
				end
				if (res.unit_y !== w.uy) begin
					$error("unit_y expected %0d actual %0d", w.uy, res.unit_y);
					mismatches++;
				end
				if (res.unit_z !== w.uz) begin
					$error("unit_z expected %0d actual %0d", w.uz, res.unit_z);
					mismatches++;
				end
				if (res.magnitude !== w.mag) begin
					$error("magnitude expected %0d actual %0d", w.mag, res.magnitude);
					mismatches++;
				end
				if (res.zero_vector !== w.zero) begin
					$error("zero_vector expected %0d actual %0d", w.zero, res.zero_vector);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((vec.valid && vec.ready) || (res.valid && res.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit && !sending_done) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		wait (sending_done);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0 && pending_units.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
